### rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is high
`define TLDR_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tldr check failed");

// clocked check that also holds during reset
`define TLDR_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tldr check failed");

`endif

### rtl/tldr_pkg.sv
package tldr_pkg;

   localparam int REQ_W = 40;
   localparam int RSP_W = 8;
   localparam int DIV_STEPS = 12;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic REG_BRUSH_RADIUS = 1'b0;
   localparam logic [3:0] RADIUS_RESET = 4'd4;
   localparam logic [7:0] INK_FULL = 8'hFF;

   typedef struct packed {
      logic       start;
      logic [3:0] dividend_m;
      logic [3:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quot;
   } div_rsp_type;

endpackage

### rtl/tldr_ram.sv
module tldr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/tldr_div.sv
module tldr_div import tldr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [11:0] num_ff, num_in;
   logic [4:0]  rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic [5:0]  trial;
   logic        fits;

   // restoring division of m*255 by the radius, one quotient bit a cycle
   assign trial = {rem_ff, num_ff[11]};
   assign fits  = trial >= {2'b00, div_req.divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         num_in = {num_ff[10:0], 1'b0};
         rem_in = fits ? 5'(trial - {2'b00, div_req.divisor}) : trial[4:0];
         quo_in = {quo_ff[6:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         num_in  = {div_req.dividend_m, 8'd0} - {8'd0, div_req.dividend_m};
         rem_in  = 5'd0;
         quo_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

### rtl/thick_line_disc_rasterizer.sv
// Thick line rasterizer: keeps a GRID_SIZE x GRID_SIZE 8-bit image in one
// single-port-write RAM and draws segments with a disc brush of brush_radius.
// After reset, and for every clear word, the image is swept to zero at one
// pixel a cycle, with req_tready low. A read word reads the RAM and then
// registers the pixel as the response. A draw word runs one segment point
// after another, with a setup state for each point; each point walks the
// circle, and each circle step finds the edge value (with the radius divider
// when needed) and then visits each of its symmetric edge pixels in turn: a clipped one is skipped,
// else it is read and, unless full, written and its column pixels filled.
module thick_line_disc_rasterizer import tldr_pkg::*; #(
   parameter int GRID_SIZE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // operation, start_x, start_y, end_x, end_y, read_row, read_col, pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pixel_value
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int AW = $clog2(DEPTH);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RSP   = 4'd2;
   localparam logic [3:0] S_POINT = 4'd3;
   localparam logic [3:0] S_VAL   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_EDGE  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_FILL  = 4'd8;
   localparam logic [3:0] S_NEXT  = 4'd9;

   function automatic logic [AW-1:0] pix_addr(logic signed [7:0] p, logic signed [7:0] q);
      return AW'(p[5:0]) * AW'(GRID_SIZE) + AW'(q[5:0]);
   endfunction

   function automatic logic on_grid(logic signed [7:0] p);
      return !p[7] && (p[6:0] < 7'(GRID_SIZE));
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [3:0]        radius_ff, radius_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rd_in_ff, rd_in_in;
   logic              major_y_ff, major_y_in;
   logic              step_neg_ff, step_neg_in;
   logic [5:0]        walk_ff, walk_in;
   logic [5:0]        end_ff, end_in;
   logic [5:0]        minor_ff, minor_in;
   logic signed [8:0] rem_ff, rem_in;
   logic [6:0]        twod_ff, twod_in;
   logic signed [7:0] inc_ff, inc_in;
   logic [5:0]        cx_ff, cx_in;
   logic [5:0]        cy_ff, cy_in;
   logic [4:0]        x_ff, x_in;
   logic [4:0]        y_ff, y_in;
   logic signed [11:0] e_ff, e_in;
   logic [7:0]        val_ff, val_in;
   logic [2:0]        k_ff, k_in;
   logic [4:0]        j_ff, j_in;
   logic signed [7:0] px_ff, px_in;
   logic signed [7:0] py_ff, py_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              below_ff, below_in;

   logic [1:0]  f_op;
   logic [5:0]  f_sx, f_sy, f_ex, f_ey;
   logic [4:0]  f_row, f_col;
   logic        req_acc;
   logic signed [6:0] dx, dy;
   logic [5:0]  adx, ady;
   logic [3:0]  r_eff;
   logic signed [12:0] m_val;
   logic signed [7:0] sa, sb, dpx, dpy, px_c, py_c, pi_c;
   logic [4:0]  y1;
   logic signed [11:0] e1, e2;
   logic [4:0]  x1;
   logic signed [9:0] r2;

   logic        ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]  ram_wdata, ram_rdata;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign f_op  = req_tdata[1:0];
   assign f_sx  = req_tdata[7:2];
   assign f_sy  = req_tdata[13:8];
   assign f_ex  = req_tdata[19:14];
   assign f_ey  = req_tdata[25:20];
   assign f_row = req_tdata[30:26];
   assign f_col = req_tdata[35:31];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign dx  = $signed({1'b0, f_ex}) - $signed({1'b0, f_sx});
   assign dy  = $signed({1'b0, f_ey}) - $signed({1'b0, f_sy});
   assign adx = dx[6] ? 6'(-dx) : dx[5:0];
   assign ady = dy[6] ? 6'(-dy) : dy[5:0];

   assign r_eff = (radius_ff == 4'd0) ? 4'd1 : radius_ff;
   assign m_val = $signed({9'd0, r_eff}) - 13'(e_ff);

   // edge pixel k of the eight symmetric ones
   assign sa = $signed({3'd0, x_ff});
   assign sb = $signed({3'd0, y_ff});
   always_comb begin
      case (k_ff)
         3'd0: begin dpx = sa;  dpy = sb;  end
         3'd1: begin dpx = sb;  dpy = sa;  end
         3'd2: begin dpx = -sb; dpy = sa;  end
         3'd3: begin dpx = -sa; dpy = sb;  end
         3'd4: begin dpx = -sa; dpy = -sb; end
         3'd5: begin dpx = -sb; dpy = -sa; end
         3'd6: begin dpx = sb;  dpy = -sa; end
         default: begin dpx = sa; dpy = -sb; end
      endcase
   end
   assign px_c = $signed({2'd0, cx_ff}) + dpx;
   assign py_c = $signed({2'd0, cy_ff}) + dpy;
   assign pi_c = below_ff ? $signed({2'd0, cy_ff}) + $signed({3'd0, j_ff})
                          : $signed({2'd0, cy_ff}) - $signed({3'd0, j_ff});

   // midpoint circle step
   assign y1 = y_ff + 5'd1;
   assign e1 = e_ff + 12'sd1 + $signed({6'd0, y1, 1'b0});
   assign x1 = x_ff - 5'd1;
   assign e2 = e1 + 12'sd1 - $signed({6'd0, x1, 1'b0});

   // minor axis remainder after one step
   assign r2 = rem_ff + inc_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      radius_in   = radius_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rd_in_in    = rd_in_ff;
      major_y_in  = major_y_ff;
      step_neg_in = step_neg_ff;
      walk_in     = walk_ff;
      end_in      = end_ff;
      minor_in    = minor_ff;
      rem_in      = rem_ff;
      twod_in     = twod_ff;
      inc_in      = inc_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      e_in        = e_ff;
      val_in      = val_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      cnt_in      = cnt_ff;
      below_in    = below_ff;
      ram_we      = 1'b0;
      ram_waddr   = clr_ff;
      ram_wdata   = 8'd0;
      ram_re      = 1'b0;
      ram_raddr   = pix_addr(px_c, py_c);
      div_req.start      = 1'b0;
      div_req.dividend_m = m_val[3:0];
      div_req.divisor    = r_eff;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_BRUSH_RADIUS) begin
         radius_in = csr_pwdata[3:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ram_raddr = pix_addr($signed({3'd0, f_row}), $signed({3'd0, f_col}));
            if (req_acc) begin
               case (f_op)
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  OP_DRAW: begin
                     state_in = S_POINT;
                     if (ady < adx) begin
                        major_y_in  = 1'b0;
                        walk_in     = f_sx;
                        end_in      = f_ex;
                        step_neg_in = dx[6];
                        minor_in    = f_sy;
                        rem_in      = $signed({3'd0, adx});
                        twod_in     = {adx, 1'b0};
                        inc_in      = {dy, 1'b0};
                     end else begin
                        major_y_in  = 1'b1;
                        walk_in     = f_sy;
                        end_in      = f_ey;
                        step_neg_in = dy[6];
                        minor_in    = f_sx;
                        rem_in      = $signed({3'd0, ady});
                        twod_in     = {ady, 1'b0};
                        inc_in      = {dx, 1'b0};
                     end
                  end
                  OP_READ: begin
                     rd_in_in = (7'(f_row) < 7'(GRID_SIZE)) && (7'(f_col) < 7'(GRID_SIZE));
                     ram_re   = 1'b1;
                     state_in = S_RSP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_in_ff ? ram_rdata : 8'd0;
               state_in     = S_IDLE;
            end
         end
         S_POINT: begin
            cx_in    = major_y_ff ? minor_ff : walk_ff;
            cy_in    = major_y_ff ? walk_ff : minor_ff;
            x_in     = {1'b0, r_eff};
            y_in     = 5'd0;
            e_in     = 12'sd0;
            state_in = S_VAL;
         end
         S_VAL: begin
            k_in = 3'd0;
            if (m_val <= 13'sd0) begin
               val_in   = 8'd0;
               state_in = S_EDGE;
            end else if (m_val >= $signed({9'd0, r_eff})) begin
               val_in   = INK_FULL;
               state_in = S_EDGE;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               val_in   = div_rsp.quot;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            px_in    = px_c;
            py_in    = py_c;
            below_in = (k_ff < 3'd4);
            cnt_in   = (k_ff == 3'd1 || k_ff == 3'd2 || k_ff == 3'd5 || k_ff == 3'd6)
                       ? x_ff : y_ff;
            if (on_grid(px_c) && on_grid(py_c)) begin
               ram_re   = 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_CHECK: begin
            j_in = 5'd0;
            if (ram_rdata != INK_FULL) begin
               ram_we    = 1'b1;
               ram_waddr = pix_addr(px_ff, py_ff);
               ram_wdata = val_ff;
               state_in  = (cnt_ff == 5'd0) ? S_NEXT : S_FILL;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_FILL: begin
            ram_we    = on_grid(pi_c);
            ram_waddr = pix_addr(px_ff, pi_c);
            ram_wdata = INK_FULL;
            j_in      = j_ff + 5'd1;
            if (j_ff == cnt_ff - 5'd1) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (k_ff != 3'd7) begin
               k_in     = k_ff + 3'd1;
               state_in = S_EDGE;
            end else begin
               y_in = y1;
               // 2*(e-x)+1 > 0 is e >= x
               if (e1 >= $signed({7'd0, x_ff})) begin
                  x_in = x1;
                  e_in = e2;
               end else begin
                  e_in = e1;
               end
               if ((e1 >= $signed({7'd0, x_ff}) ? x1 : x_ff) >= y1) begin
                  state_in = S_VAL;
               end else if (walk_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  walk_in  = step_neg_ff ? walk_ff - 6'd1 : walk_ff + 6'd1;
                  state_in = S_POINT;
                  if (r2 >= $signed({3'd0, twod_ff})) begin
                     rem_in   = 9'(r2 - $signed({3'd0, twod_ff}));
                     minor_in = minor_ff + 6'd1;
                  end else if (r2 < 10'sd0) begin
                     rem_in   = 9'(r2 + $signed({3'd0, twod_ff}));
                     minor_in = minor_ff - 6'd1;
                  end else begin
                     rem_in = 9'(r2);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         radius_ff    <= RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rd_in_ff    <= rd_in_in;
      major_y_ff  <= major_y_in;
      step_neg_ff <= step_neg_in;
      walk_ff     <= walk_in;
      end_ff      <= end_in;
      minor_ff    <= minor_in;
      rem_ff      <= rem_in;
      twod_ff     <= twod_in;
      inc_ff      <= inc_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      e_ff        <= e_in;
      val_ff      <= val_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      cnt_ff      <= cnt_in;
      below_ff    <= below_in;
   end

   tldr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_image (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   tldr_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BRUSH_RADIUS) ? {28'd0, radius_ff} : 32'd0;

endmodule

### rtl/tldr_checker.sv
`include "assert_macros.svh"

module tldr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // the image sweep after reset keeps the input closed
   `TLDR_ASSERT(a_no_ready_after_reset, clock, $past(reset) |-> !req_tready)

   // a fresh result only follows a cycle of internal work
   `TLDR_ASSERT_RST(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready))

   // a stalled word holds
   `TLDR_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

endmodule

bind thick_line_disc_rasterizer tldr_checker u_checker (.*);

### tb/tb_thick_line_disc_rasterizer.sv
`timescale 1ns / 100ps

module tb_thick_line_disc_rasterizer;
   import tldr_pkg::*;

   localparam int GRID = 32;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // operation, start_x, start_y, end_x, end_y, read_row, read_col, pad
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // pixel_value
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   thick_line_disc_rasterizer #(.GRID_SIZE(GRID)) DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [REQ_W-1:0] pending_words[$];
   logic [7:0]       pixel_expect[$];
   logic [7:0]       image[0:GRID*GRID-1];
   logic [3:0]       radius_reg = RADIUS_RESET;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   bit               hold_kick = 1'b0;
   bit               hold_seen = 1'b0;
   int               hold_cnt = 0;
   bit               failed = 1'b0;

   function automatic logic [REQ_W-1:0] pack_word(logic [1:0] op, logic [5:0] sx,
         logic [5:0] sy, logic [5:0] ex, logic [5:0] ey, logic [4:0] rr, logic [4:0] rc);
      return {4'b0, rc, rr, ey, ex, sy, sx, op};
   endfunction

   function automatic bit on_grid(int a, int b);
      return a >= 0 && b >= 0 && a < GRID && b < GRID;
   endfunction

   function automatic void ink_edge(int px, int py, int cy, int r, int err, bit below);
      int v;
      if (!on_grid(px, py) || image[px*GRID+py] == INK_FULL) return;
      v = (r - err) > 0 ? ((r - err) * 255) / r : 0;
      if (v > 255) v = 255;
      image[px*GRID+py] = v[7:0];
      if (below) begin
         for (int i = cy; i < py; i++)
            if (on_grid(px, i)) image[px*GRID+i] = INK_FULL;
      end else begin
         for (int i = cy; i > py; i--)
            if (on_grid(px, i)) image[px*GRID+i] = INK_FULL;
      end
   endfunction

   function automatic void stamp_disc(int cx, int cy);
      int r, a, b, e;
      r = (radius_reg == 0) ? 1 : int'(radius_reg);
      a = r;
      b = 0;
      e = 0;
      while (a >= b) begin
         ink_edge(cx + a, cy + b, cy, r, e, 1'b1);
         ink_edge(cx + b, cy + a, cy, r, e, 1'b1);
         ink_edge(cx - b, cy + a, cy, r, e, 1'b1);
         ink_edge(cx - a, cy + b, cy, r, e, 1'b1);
         ink_edge(cx - a, cy - b, cy, r, e, 1'b0);
         ink_edge(cx - b, cy - a, cy, r, e, 1'b0);
         ink_edge(cx + b, cy - a, cy, r, e, 1'b0);
         ink_edge(cx + a, cy - b, cy, r, e, 1'b0);
         b += 1;
         e += 1 + 2 * b;
         if (2 * (e - a) + 1 > 0) begin
            a -= 1;
            e += 1 - 2 * a;
         end
      end
   endfunction

   // base + off*num/den, rounded half up
   function automatic int round_lerp(int base, int off, int num, int den);
      int n, d;
      n = off * num;
      d = den;
      if (d == 0) return base;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      return (2 * base * d + 2 * n + d) / (2 * d);
   endfunction

   function automatic void draw_segment(int sx, int sy, int ex, int ey);
      int dx, dy, adx, ady, stp, p;
      bit walking;
      dx = ex - sx;
      dy = ey - sy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      walking = 1'b1;
      if (ady < adx) begin
         stp = dx > 0 ? 1 : -1;
         p = sx;
         while (walking) begin
            stamp_disc(p, round_lerp(sy, p - sx, dy, dx));
            if (p == ex) walking = 1'b0;
            else p += stp;
         end
      end else begin
         stp = dy >= 0 ? 1 : -1;
         p = sy;
         while (walking) begin
            stamp_disc(round_lerp(sx, p - sy, dx, dy), p);
            if (p == ey) walking = 1'b0;
            else p += stp;
         end
      end
   endfunction

   function automatic void apply_word(logic [REQ_W-1:0] w);
      case (w[1:0])
         OP_CLEAR: begin
            foreach (image[i]) image[i] = '0;
         end
         OP_DRAW: begin
            draw_segment(int'(w[7:2]), int'(w[13:8]), int'(w[19:14]), int'(w[25:20]));
         end
         OP_READ: begin
            pixel_expect.push_back(image[int'(w[30:26])*GRID + int'(w[35:31])]);
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_word(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_words.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_expect.size() == 0) begin
               $display("%0t: unexpected pixel word, expected none actual %0d",
                        $time, rsp_tdata);
               failed = 1'b1;
            end else if (rsp_tdata !== pixel_expect[0]) begin
               $display("%0t: pixel_value mismatch, expected %0d actual %0d",
                        $time, pixel_expect[0], rsp_tdata);
               failed = 1'b1;
               void'(pixel_expect.pop_front());
            end else begin
               void'(pixel_expect.pop_front());
            end
         end
         if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_cnt <= 20000;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= stall_pct;
         end
      end
   end

   task automatic write_radius(logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_BRUSH_RADIUS, 2'b00};
      csr_pwdata <= {28'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      radius_reg = value;
   endtask

   task automatic add_read(int row, int col);
      pending_words.push_back(pack_word(OP_READ, 6'($urandom), 6'($urandom), 6'($urandom),
                                        6'($urandom), 5'(row), 5'(col)));
   endtask

   task automatic add_draw(int sx, int sy, int ex, int ey);
      pending_words.push_back(pack_word(OP_DRAW, 6'(sx), 6'(sy), 6'(ex), 6'(ey),
                                        5'($urandom), 5'($urandom)));
   endtask

   function automatic int clip6(int v);
      return v < 0 ? 0 : (v > 63 ? 63 : v);
   endfunction

   // short strokes and random reads, plus some long strokes when allowed, clear and unused words
   task automatic add_random(int n, bit allow_long);
      int k, sx, sy, ex, ey;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 5) begin
            pending_words.push_back(pack_word(OP_CLEAR, 6'($urandom), 6'($urandom),
                                              6'($urandom), 6'($urandom), 5'($urandom),
                                              5'($urandom)));
         end else if (k < 45) begin
            sx = $urandom_range(63);
            sy = $urandom_range(63);
            if (allow_long && $urandom_range(9) == 0) begin
               ex = $urandom_range(63);
               ey = $urandom_range(63);
            end else begin
               ex = clip6(sx + int'($urandom_range(12)) - 6);
               ey = clip6(sy + int'($urandom_range(12)) - 6);
            end
            add_draw(sx, sy, ex, ey);
         end else if (k < 93) begin
            add_read($urandom_range(31), $urandom_range(31));
         end else begin
            pending_words.push_back(pack_word(OP_UNUSED, 6'($urandom), 6'($urandom),
                                              6'($urandom), 6'($urandom), 5'($urandom),
                                              5'($urandom)));
         end
      end
   endtask

   // a closing read drains any draw still in progress
   task automatic drain;
      add_read($urandom_range(31), $urandom_range(31));
      wait (pending_words.size() == 0 && !req_tvalid && pixel_expect.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(logic [3:0] radius, int send_pct, int stall, int n,
                            bit allow_long);
      write_radius(radius);
      send_idle_pct = send_pct;
      stall_pct = stall;
      add_random(n, allow_long);
      drain();
   endtask

   initial begin
      foreach (image[i]) image[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // reset radius in effect, image starts cleared
      add_read(0, 0);
      add_read(31, 31);
      add_draw(0, 0, 63, 63);
      add_read(0, 0);
      add_read(4, 0);
      add_draw(10, 5, 10, 20);
      add_read(10, 12);
      add_read(14, 12);
      add_draw(20, 20, 20, 20);
      add_read(20, 20);
      add_read(24, 20);
      add_draw(30, 2, 5, 9);
      add_draw(63, 40, 50, 0);
      add_draw(2, 63, 8, 40);
      add_read(31, 0);
      add_read(0, 31);
      pending_words.push_back(pack_word(OP_UNUSED, 6'h3f, 6'h3f, 6'h3f, 6'h3f,
                                        5'h1f, 5'h1f));
      add_read(21, 18);
      pending_words.push_back(pack_word(OP_CLEAR, 6'h3f, 6'h3f, 6'h3f, 6'h3f,
                                        5'h1f, 5'h1f));
      add_read(20, 20);
      add_read(10, 12);
      drain();

      run_phase(4'd0, 0, 0, 45, 1'b1);
      run_phase(4'd15, 83, 0, 40, 1'b0);
      run_phase(4'd1, 0, 83, 45, 1'b1);
      run_phase(4'($urandom_range(14, 2)), 22, 22, 45, 1'b1);
      run_phase(4'd8, 0, 0, 45, 1'b1);

      // long receiver hold while reads keep arriving
      write_radius(4'd5);
      send_idle_pct = 0;
      stall_pct = 0;
      add_draw(16, 8, 16, 24);
      hold_kick = ~hold_kick;
      for (int i = 0; i < 40; i++) add_read(16, $urandom_range(31));
      drain();

      repeat (50) @(posedge clock);
      if (!failed) begin
         $display("** thick_line_disc_rasterizer: PASSED **");
      end else begin
         $display("** thick_line_disc_rasterizer: FAILED **");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("** thick_line_disc_rasterizer: FAILED **");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/tldr_pkg.sv
rtl/tldr_ram.sv
rtl/tldr_div.sv
rtl/thick_line_disc_rasterizer.sv
rtl/tldr_checker.sv
tb/tb_thick_line_disc_rasterizer.sv
